### design/midi_note_arpeggiator_top_assert.svh
// Assertion macros for the MIDI note arpeggiator checker.
// Used by the checker only; depends on nothing else.
`ifndef MIDI_NOTE_ARPEGGIATOR_TOP_ASSERT_SVH
`define MIDI_NOTE_ARPEGGIATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MNA_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("arpeggiator check failed");

// Next-cycle implication, disabled during reset.
`define MNA_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("arpeggiator check failed");

`endif

### design/mna_pkg.sv
// Shared constants, types and helper functions of the MIDI note arpeggiator.
// Depends on nothing; used by the core, the top level and the checker.
package mna_pkg;

   localparam int MAX_HELD_NOTES = 16;
   localparam int IDX_W          = $clog2(MAX_HELD_NOTES);
   localparam int CNT_W          = $clog2(MAX_HELD_NOTES + 1);
   localparam int REM_W          = CNT_W + 1;

   localparam int CMD_W    = 2;
   localparam int STATUS_W = 8;
   localparam int PITCH_W  = 7;
   localparam int VEL_W    = 7;
   localparam int ENTRY_W  = PITCH_W + VEL_W;
   localparam int MODE_W   = 2;
   localparam int SEED_W   = 16;
   localparam int BIT_W    = $clog2(SEED_W);
   localparam int ALU_W    = (PITCH_W > REM_W) ? PITCH_W : REM_W;
   localparam int CSR_IDX_W = 1;

   localparam logic [STATUS_W-1:0] STATUS_NOTE_ON  = 8'd144;
   localparam logic [STATUS_W-1:0] STATUS_NOTE_OFF = 8'd128;
   localparam logic [SEED_W-1:0]   LFSR_TAPS       = 16'hB400;
   localparam logic [SEED_W-1:0]   SEED_RESET      = 16'd1;

   localparam logic [CMD_W-1:0] CMD_NOTE    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_STEP    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

   localparam logic [MODE_W-1:0] MODE_RANDOM = 2'd0;
   localparam logic [MODE_W-1:0] MODE_UP     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DOWN   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ARP_MODE    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANDOM_SEED = 1'b1;

   typedef struct packed {
      logic [MODE_W-1:0] arp_mode;
      logic              seed_load;
      logic [SEED_W-1:0] seed;
   } cfg_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PITCH_W-1:0]  note;
      logic [VEL_W-1:0]    velocity;
      logic                last;
   } result_type;

   // Galois LFSR, shifting right.
   function automatic logic [SEED_W-1:0] lfsr_next(input logic [SEED_W-1:0] x);
      logic [SEED_W-1:0] v;
      v = x >> 1;
      if (x[0]) begin
         v = v ^ LFSR_TAPS;
      end
      return v;
   endfunction

endpackage

### design/mna_core.sv
// Sequencer of the arpeggiator: held-note memory, sorted insert, removal,
// step selection with a bit-serial modulo. Depends on mna_pkg.
module mna_core
   import mna_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [STATUS_W-1:0] req_status_byte,
   input  logic [PITCH_W-1:0]  req_note_number,
   input  logic [VEL_W-1:0]    req_velocity,
   output logic                idle,
   input  cfg_type             cfg,
   input  logic                room,
   output logic                push,
   output result_type          push_data
);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_FIND    = 4'd1;
   localparam logic [3:0] ST_FIND_W  = 4'd2;
   localparam logic [3:0] ST_SHIFT   = 4'd3;
   localparam logic [3:0] ST_SHIFT_W = 4'd4;
   localparam logic [3:0] ST_RM      = 4'd5;
   localparam logic [3:0] ST_RM_W    = 4'd6;
   localparam logic [3:0] ST_OFF     = 4'd7;
   localparam logic [3:0] ST_PICK    = 4'd8;
   localparam logic [3:0] ST_MOD     = 4'd9;
   localparam logic [3:0] ST_READ    = 4'd10;
   localparam logic [3:0] ST_READ_W  = 4'd11;
   localparam logic [3:0] ST_ON      = 4'd12;

   logic [3:0]         state_ff, state_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [PITCH_W-1:0] pitch_ff, pitch_in;
   logic [VEL_W-1:0]   vel_ff, vel_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   step_ff, step_in;
   logic               snd_valid_ff, snd_valid_in;
   logic [ENTRY_W-1:0] snd_entry_ff, snd_entry_in;
   logic [SEED_W-1:0]  lfsr_ff, lfsr_in;
   logic [CNT_W-1:0]   ptr_ff, ptr_in;
   logic [CNT_W-1:0]   wr_ff, wr_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;
   logic [ENTRY_W-1:0] rd_data_ff;

   logic [ENTRY_W-1:0] mem [MAX_HELD_NOTES];
   logic               mem_re, mem_we;
   logic [IDX_W-1:0]   rd_addr, wr_addr;
   logic [ENTRY_W-1:0] wr_data;

   // Shared subtract and compare unit.
   logic [ALU_W-1:0]   alu_a, alu_b;
   logic [ALU_W:0]     alu_diff;
   logic               alu_ge, alu_eq;

   logic [REM_W-1:0]   shifted;
   logic [CNT_W-1:0]   rem_new;
   logic [CNT_W-1:0]   step_up;
   logic [CNT_W-1:0]   ptr_dec;
   logic [PITCH_W-1:0] rd_pitch;
   logic               will_sound;

   assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
   assign alu_ge   = ~alu_diff[ALU_W];
   assign alu_eq   = (alu_diff == '0);

   assign shifted    = {rem_ff, lfsr_ff[bit_ff]};
   assign step_up    = CNT_W'(step_ff) + CNT_W'(1);
   assign ptr_dec    = ptr_ff - CNT_W'(1);
   assign rd_pitch   = rd_data_ff[ENTRY_W-1 -: PITCH_W];
   assign will_sound = (cmd_ff == CMD_STEP) && (count_ff != '0);
   assign idle       = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      pitch_in     = pitch_ff;
      vel_in       = vel_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      snd_valid_in = snd_valid_ff;
      snd_entry_in = snd_entry_ff;
      lfsr_in      = lfsr_ff;
      ptr_in       = ptr_ff;
      wr_in        = wr_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      mem_re       = 1'b0;
      mem_we       = 1'b0;
      rd_addr      = '0;
      wr_addr      = '0;
      wr_data      = '0;
      push         = 1'b0;
      push_data    = '0;
      alu_a        = '0;
      alu_b        = '0;
      rem_new      = shifted[CNT_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_command;
               pitch_in = req_note_number;
               vel_in   = req_velocity;
               ptr_in   = '0;
               wr_in    = '0;
               if (req_command == CMD_NOTE) begin
                  if (req_status_byte == STATUS_NOTE_ON && req_velocity != '0) begin
                     // A full list drops the note.
                     if (count_ff < CNT_W'(MAX_HELD_NOTES)) begin
                        state_in = ST_FIND;
                     end
                  end else if (req_status_byte == STATUS_NOTE_ON ||
                               req_status_byte == STATUS_NOTE_OFF) begin
                     state_in = ST_RM;
                  end
               end else if (req_command == CMD_STEP || req_command == CMD_RELEASE) begin
                  if (snd_valid_ff) begin
                     state_in = ST_OFF;
                  end else if (req_command == CMD_STEP && count_ff != '0) begin
                     state_in = ST_PICK;
                  end
               end
            end
         end
         ST_FIND: begin
            if (ptr_ff == count_ff) begin
               wr_in    = ptr_ff;
               ptr_in   = count_ff;
               state_in = ST_SHIFT;
            end else begin
               mem_re   = 1'b1;
               rd_addr  = ptr_ff[IDX_W-1:0];
               state_in = ST_FIND_W;
            end
         end
         ST_FIND_W: begin
            // Equal pitches stay ahead of the new note.
            alu_a = ALU_W'(pitch_ff);
            alu_b = ALU_W'(rd_pitch);
            if (alu_ge) begin
               ptr_in   = ptr_ff + CNT_W'(1);
               state_in = ST_FIND;
            end else begin
               wr_in    = ptr_ff;
               ptr_in   = count_ff;
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (ptr_ff == wr_ff) begin
               mem_we   = 1'b1;
               wr_addr  = wr_ff[IDX_W-1:0];
               wr_data  = {pitch_ff, vel_ff};
               count_in = count_ff + CNT_W'(1);
               state_in = ST_IDLE;
            end else begin
               mem_re   = 1'b1;
               rd_addr  = ptr_dec[IDX_W-1:0];
               state_in = ST_SHIFT_W;
            end
         end
         ST_SHIFT_W: begin
            mem_we   = 1'b1;
            wr_addr  = ptr_ff[IDX_W-1:0];
            wr_data  = rd_data_ff;
            ptr_in   = ptr_dec;
            state_in = ST_SHIFT;
         end
         ST_RM: begin
            if (ptr_ff == count_ff) begin
               count_in = wr_ff;
               if (wr_ff == '0) begin
                  step_in = '0;
               end else if (CNT_W'(step_ff) >= wr_ff) begin
                  step_in = IDX_W'(wr_ff - CNT_W'(1));
               end
               state_in = ST_IDLE;
            end else begin
               mem_re   = 1'b1;
               rd_addr  = ptr_ff[IDX_W-1:0];
               state_in = ST_RM_W;
            end
         end
         ST_RM_W: begin
            alu_a = ALU_W'(rd_pitch);
            alu_b = ALU_W'(pitch_ff);
            if (!alu_eq) begin
               mem_we  = 1'b1;
               wr_addr = wr_ff[IDX_W-1:0];
               wr_data = rd_data_ff;
               wr_in   = wr_ff + CNT_W'(1);
            end
            ptr_in   = ptr_ff + CNT_W'(1);
            state_in = ST_RM;
         end
         ST_OFF: begin
            if (room) begin
               push               = 1'b1;
               push_data.status   = STATUS_NOTE_OFF;
               push_data.note     = snd_entry_ff[ENTRY_W-1 -: PITCH_W];
               push_data.velocity = snd_entry_ff[VEL_W-1:0];
               push_data.last     = ~will_sound;
               snd_valid_in       = 1'b0;
               state_in           = will_sound ? ST_PICK : ST_IDLE;
            end
         end
         ST_PICK: begin
            if (cfg.arp_mode == MODE_UP) begin
               alu_a    = ALU_W'(step_up);
               alu_b    = ALU_W'(count_ff);
               step_in  = alu_ge ? '0 : step_up[IDX_W-1:0];
               state_in = ST_READ;
            end else if (cfg.arp_mode == MODE_DOWN) begin
               step_in  = (step_ff == '0) ? IDX_W'(count_ff - CNT_W'(1))
                                          : step_ff - IDX_W'(1);
               state_in = ST_READ;
            end else begin
               lfsr_in  = lfsr_next(lfsr_ff);
               rem_in   = '0;
               bit_in   = BIT_W'(SEED_W - 1);
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            // Restoring division, one dividend bit per cycle, MSB first.
            alu_a = ALU_W'(shifted);
            alu_b = ALU_W'(count_ff);
            if (alu_ge) begin
               rem_new = alu_diff[CNT_W-1:0];
            end
            rem_in = rem_new;
            if (bit_ff == '0) begin
               step_in  = rem_new[IDX_W-1:0];
               state_in = ST_READ;
            end else begin
               bit_in = bit_ff - BIT_W'(1);
            end
         end
         ST_READ: begin
            mem_re   = 1'b1;
            rd_addr  = step_ff;
            state_in = ST_READ_W;
         end
         ST_READ_W: begin
            snd_entry_in = rd_data_ff;
            snd_valid_in = 1'b1;
            state_in     = ST_ON;
         end
         ST_ON: begin
            if (room) begin
               push               = 1'b1;
               push_data.status   = STATUS_NOTE_ON;
               push_data.note     = snd_entry_ff[ENTRY_W-1 -: PITCH_W];
               push_data.velocity = snd_entry_ff[VEL_W-1:0];
               push_data.last     = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cfg.seed_load) begin
         lfsr_in = cfg.seed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         snd_valid_ff <= 1'b0;
         lfsr_ff      <= SEED_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         snd_valid_ff <= snd_valid_in;
         lfsr_ff      <= lfsr_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      pitch_ff     <= pitch_in;
      vel_ff       <= vel_in;
      snd_entry_ff <= snd_entry_in;
      ptr_ff       <= ptr_in;
      wr_ff        <= wr_in;
      rem_ff       <= rem_in;
      bit_ff       <= bit_in;
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
   end

endmodule

### design/midi_note_arpeggiator_top.sv
// Channel  Dir  Handshake             Payload
// req      in   req_valid, req_stall  command, status byte, note number, velocity
// rsp      out  rsp_valid, rsp_stall  status, note, velocity, last
// csr      in   csr_we                csr_index, csr_wdata
//
// After an item is taken, a note-on or a note-off keeps the input stalled while the core
// walks the list of stored notes. A step stalls it through the states PICK, READ,
// READ_W and ON, with the bit-serial modulo (MOD) in random mode and OFF first when a note
// is sounding; a release stalls it through OFF only when a note is sounding.
// The single-port note memory and the bit-serial modulo set the length of these stalls.
// Reset is synchronous and empties the note list; the LFSR restarts at 1.
// Results wait in a two-entry output buffer; the core halts while it is full.
// Depends on mna_pkg and mna_core.
module midi_note_arpeggiator_top
   import mna_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [STATUS_W-1:0]  req_status_byte,
   input  logic [PITCH_W-1:0]   req_note_number,
   input  logic [VEL_W-1:0]     req_velocity,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STATUS_W-1:0]  rsp_out_status,
   output logic [PITCH_W-1:0]   rsp_out_note,
   output logic [VEL_W-1:0]     rsp_out_velocity,
   output logic                 rsp_last,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SEED_W-1:0]    csr_wdata
);

   logic [MODE_W-1:0] arp_mode_ff;
   cfg_type           cfg;
   logic              core_idle;
   logic              push;
   result_type        push_data;

   result_type        out_ff, out_in;
   result_type        spare_ff, spare_in;
   logic              out_v_ff, out_v_in;
   logic              spare_v_ff, spare_v_in;
   logic              take;

   always_ff @(posedge clock) begin
      if (reset) begin
         arp_mode_ff <= MODE_RANDOM;
      end else if (csr_we && csr_index == CSR_ARP_MODE) begin
         arp_mode_ff <= csr_wdata[MODE_W-1:0];
      end
   end

   assign cfg.arp_mode  = arp_mode_ff;
   assign cfg.seed_load = csr_we && (csr_index == CSR_RANDOM_SEED);
   assign cfg.seed      = csr_wdata;

   mna_core u_core (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_command     (req_command),
      .req_status_byte (req_status_byte),
      .req_note_number (req_note_number),
      .req_velocity    (req_velocity),
      .idle            (core_idle),
      .cfg             (cfg),
      .room            (~spare_v_ff),
      .push            (push),
      .push_data       (push_data)
   );

   assign req_stall = ~core_idle;
   assign take      = out_v_ff && !rsp_stall;

   always_comb begin
      out_v_in   = out_v_ff;
      out_in     = out_ff;
      spare_v_in = spare_v_ff;
      spare_in   = spare_ff;
      if (!out_v_ff) begin
         out_v_in = push;
         out_in   = push_data;
      end else if (take) begin
         if (spare_v_ff) begin
            out_in     = spare_ff;
            spare_v_in = push;
            spare_in   = push_data;
         end else begin
            out_v_in = push;
            out_in   = push_data;
         end
      end else if (push) begin
         spare_v_in = 1'b1;
         spare_in   = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff   <= 1'b0;
         spare_v_ff <= 1'b0;
      end else begin
         out_v_ff   <= out_v_in;
         spare_v_ff <= spare_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff   <= out_in;
      spare_ff <= spare_in;
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_out_status   = out_ff.status;
   assign rsp_out_note     = out_ff.note;
   assign rsp_out_velocity = out_ff.velocity;
   assign rsp_last         = out_ff.last;

endmodule

### design/mna_checker.sv
// Port-level checks of the MIDI note arpeggiator and their bind to the top.
// Depends on mna_pkg and the assertion macros header.
`include "midi_note_arpeggiator_top_assert.svh"

module mna_checker
   import mna_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [STATUS_W-1:0]  rsp_out_status,
   input logic [PITCH_W-1:0]   rsp_out_note,
   input logic [VEL_W-1:0]     rsp_out_velocity,
   input logic                 rsp_last
);

   // Only note-on and note-off messages ever leave the block.
   `MNA_ASSERT_IMPLY(a_status_kind, clock, reset, rsp_valid,
      rsp_out_status == STATUS_NOTE_ON || rsp_out_status == STATUS_NOTE_OFF)

   // A note-on always closes the results of its item.
   `MNA_ASSERT_IMPLY(a_on_is_last, clock, reset,
      rsp_valid && rsp_out_status == STATUS_NOTE_ON, rsp_last)

   // Held notes are stored only with a nonzero velocity.
   `MNA_ASSERT_IMPLY(a_velocity_set, clock, reset, rsp_valid, rsp_out_velocity != '0)

   // A stalled item is held unchanged.
   `MNA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_out_status) && $stable(rsp_out_note))

endmodule

bind midi_note_arpeggiator_top mna_checker u_mna_checker (.*);
